/* rtl/pmcs_pkg.sv */
package pmcs_pkg;

	localparam int MAX_PACKET_BYTES = 2048;
	localparam int MARK_COUNT       = 4;

	// Register file layout: four marker slots, one marker byte each
	localparam int MARK_SLOTS = 4;
	localparam int SLOT_W     = $clog2(MARK_SLOTS);
	localparam int POS_W      = 11;
	localparam int MARKERS_W  = 8 * MARK_SLOTS;
	localparam int DATA_W     = 32;
	localparam int ADDR_W     = 5;
	localparam int REG_IDX_W  = ADDR_W - 2;

	// Per-packet counters
	localparam int IDX_W   = $clog2(MAX_PACKET_BYTES + 1);
	localparam int CMP_W   = (IDX_W > POS_W) ? IDX_W : POS_W;
	localparam int MARKS_W = $clog2(MARK_SLOTS + 1);
	localparam int DROP_W  = 32;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_MARKERS = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_POS_0   = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_POS_1   = REG_IDX_W'(2);
	localparam logic [REG_IDX_W-1:0] REG_POS_2   = REG_IDX_W'(3);
	localparam logic [REG_IDX_W-1:0] REG_POS_3   = REG_IDX_W'(4);

	// Reset values
	localparam logic [MARKERS_W-1:0] MARKERS_RST = 32'h7573_6A73;
	localparam logic [POS_W-1:0]     POS_0_RST   = POS_W'(55);
	localparam logic [POS_W-1:0]     POS_1_RST   = POS_W'(60);
	localparam logic [POS_W-1:0]     POS_2_RST   = POS_W'(65);
	localparam logic [POS_W-1:0]     POS_3_RST   = POS_W'(70);

	typedef struct packed {
		logic [MARKERS_W-1:0]               marker_bytes;
		logic [MARK_SLOTS-1:0][POS_W-1:0]   mark_pos;
	} cfg_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} item_t;

	typedef struct packed {
		logic              emit;
		logic [7:0]        out_byte;
		logic              out_valid;
		logic              out_last;
		logic              verdict;
		logic [DROP_W-1:0] drop_total;
	} res_t;

endpackage

/* rtl/pmcs_check.sv */
module pmcs_check (
	input  logic           clk,
	input  logic           arst_n,
	input  pmcs_pkg::cfg_t cfg,
	input  logic           step,
	input  pmcs_pkg::item_t item,
	output pmcs_pkg::res_t res
);
	import pmcs_pkg::*;

	logic [IDX_W-1:0]   byte_idx_q;
	logic               mismatch_q;
	logic [MARKS_W-1:0] marks_q;
	logic [DROP_W-1:0]  drop_q;

	logic [SLOT_W-1:0]  slot;
	logic [7:0]         expect_byte;
	logic               in_range;
	logic               is_mark;
	logic               mismatch_nxt;
	logic [MARKS_W-1:0] marks_nxt;
	logic               drop;
	logic [DROP_W-1:0]  drop_nxt;

	// Compare only the offset of the next expected marker
	assign slot        = marks_q[SLOT_W-1:0];
	assign expect_byte = cfg.marker_bytes[(MARK_SLOTS - 1 - int'(slot)) * 8 +: 8];
	assign in_range    = byte_idx_q < IDX_W'(MAX_PACKET_BYTES);
	assign is_mark     = (marks_q < MARKS_W'(MARK_COUNT)) && in_range &&
	                     (CMP_W'(byte_idx_q) == CMP_W'(cfg.mark_pos[slot]));

	assign mismatch_nxt = mismatch_q | (is_mark && (item.in_byte != expect_byte));
	assign marks_nxt    = is_mark ? marks_q + MARKS_W'(1) : marks_q;
	assign drop         = mismatch_nxt || (marks_nxt < MARKS_W'(MARK_COUNT));
	assign drop_nxt     = drop_q + DROP_W'(drop);

	// Build the result; a marker byte inside the packet yields none
	always_comb begin
		res.emit       = !is_mark || item.in_last;
		res.out_byte   = is_mark ? 8'd0 : item.in_byte;
		res.out_valid  = !is_mark;
		res.out_last   = item.in_last;
		res.verdict    = item.in_last && drop;
		res.drop_total = item.in_last ? drop_nxt : '0;
	end

	// Advance per-packet state; clear it after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_idx_q <= '0;
			mismatch_q <= 1'b0;
			marks_q    <= '0;
			drop_q     <= '0;
		end else if (step) begin
			if (item.in_last) begin
				byte_idx_q <= '0;
				mismatch_q <= 1'b0;
				marks_q    <= '0;
				drop_q     <= drop_nxt;
			end else begin
				if (in_range) begin
					byte_idx_q <= byte_idx_q + IDX_W'(1);
				end
				mismatch_q <= mismatch_nxt;
				marks_q    <= marks_nxt;
			end
		end
	end

endmodule

/* rtl/packet_marker_check_strip.sv */
// An accepted byte is held in the input register, then its result in the result register.
// Throughput: one byte per cycle while results are not stalled; marker bytes that do not
// end a packet give no result. The rate is set by the single check stage in between.
// Reset: configuration returns to its default markers and offsets, per-packet state and
// the drop count clear at once, both pipeline registers empty; no clearing pass.
module packet_marker_check_strip (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pmcs_pkg::ADDR_W-1:0]   paddr,
	input  logic [pmcs_pkg::DATA_W-1:0]   pwdata,
	output logic [pmcs_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    in_byte,
	input  logic                          in_last,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [7:0]                    out_byte,
	output logic                          out_valid,
	output logic                          out_last,
	output logic                          verdict,
	output logic [pmcs_pkg::DROP_W-1:0]   drop_total
);
	import pmcs_pkg::*;

	cfg_t                 cfg_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;

	logic  valid_s1;
	item_t item_s1;
	res_t  res;
	logic  out_free;
	logic  adv_s1;
	logic  in_take;

	// Register writes and reads
	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.marker_bytes <= MARKERS_RST;
			cfg_q.mark_pos[0]  <= POS_0_RST;
			cfg_q.mark_pos[1]  <= POS_1_RST;
			cfg_q.mark_pos[2]  <= POS_2_RST;
			cfg_q.mark_pos[3]  <= POS_3_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MARKERS: cfg_q.marker_bytes <= pwdata[MARKERS_W-1:0];
				REG_POS_0:   cfg_q.mark_pos[0]  <= pwdata[POS_W-1:0];
				REG_POS_1:   cfg_q.mark_pos[1]  <= pwdata[POS_W-1:0];
				REG_POS_2:   cfg_q.mark_pos[2]  <= pwdata[POS_W-1:0];
				REG_POS_3:   cfg_q.mark_pos[3]  <= pwdata[POS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MARKERS: prdata = DATA_W'(cfg_q.marker_bytes);
			REG_POS_0:   prdata = DATA_W'(cfg_q.mark_pos[0]);
			REG_POS_1:   prdata = DATA_W'(cfg_q.mark_pos[1]);
			REG_POS_2:   prdata = DATA_W'(cfg_q.mark_pos[2]);
			REG_POS_3:   prdata = DATA_W'(cfg_q.mark_pos[3]);
			default:     prdata = '0;
		endcase
	end

	// Flow control: the input stage drains when the result register has room or its byte gives no result
	assign out_free = !res_valid || !res_stall;
	assign adv_s1   = valid_s1 && (out_free || !res.emit);
	assign in_stall = valid_s1 && !adv_s1;
	assign in_take  = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.in_byte <= in_byte;
			item_s1.in_last <= in_last;
		end
	end

	pmcs_check u_check (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.step   (adv_s1),
		.item   (item_s1),
		.res    (res)
	);

	// Result register: load a new result, or drop the old one once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (out_free) begin
			res_valid <= adv_s1 && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && adv_s1 && res.emit) begin
			out_byte   <= res.out_byte;
			out_valid  <= res.out_valid;
			out_last   <= res.out_last;
			verdict    <= res.verdict;
			drop_total <= res.drop_total;
		end
	end

	// A result inside a packet always carries a passed byte and no verdict
	a_mid_packet: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !out_last |-> out_valid && !verdict && (drop_total == '0))
		else $error("mid-packet result without byte or with verdict");

	// A stripped marker byte shows as zero
	a_strip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !out_valid |-> (out_byte == 8'd0) && out_last)
		else $error("stripped marker result malformed");

	// Input stage only stalls while it holds a transaction and the output is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && res_valid && res_stall)
		else $error("input stalled without a blocked output");

endmodule

/* verif/tb_packet_marker_check_strip.sv */
module tb_packet_marker_check_strip;
	timeunit 1ns;
	timeprecision 1ps;

	import pmcs_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam logic [REG_IDX_W-1:0] REG_UNUSED = REG_IDX_W'(7);

	typedef enum logic [1:0] {PACE_A, PACE_B, PACE_FULL} pace_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} pkt_byte_t;

	typedef struct packed {
		logic [7:0]        data;
		logic              kept;
		logic              last;
		logic              dropped;
		logic [DROP_W-1:0] drop_total;
	} strip_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] in_byte = 8'h00;
	logic in_last = 1'b0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic [7:0] out_byte;
	logic out_valid;
	logic out_last;
	logic verdict;
	logic [DROP_W-1:0] drop_total;

	// Stimulus and expectation stores
	pkt_byte_t   byte_backlog[$];
	strip_beat_t expected_beats[$];
	pace_t       pace = PACE_A;
	logic        in_took = 1'b0;
	int          errors = 0;
	int          cycles = 0;

	// Predicted configuration, starting from reset values
	logic [MARKERS_W-1:0] cfg_markers = MARKERS_RST;
	logic [POS_W-1:0]     cfg_pos [4] = '{POS_0_RST, POS_1_RST, POS_2_RST, POS_3_RST};

	// Predicted per-packet state
	logic [11:0]       pkt_offset = '0;
	logic              pkt_bad = 1'b0;
	logic [2:0]        marks_hit = '0;
	logic [DROP_W-1:0] drops = '0;

	packet_marker_check_strip dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.in_last(in_last),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.out_byte(out_byte),
		.out_valid(out_valid),
		.out_last(out_last),
		.verdict(verdict),
		.drop_total(drop_total)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	task automatic note_error(input string what);
		errors++;
		if (errors <= 10) begin
			$display("ERROR at %0t: %s", $realtime, what);
		end
	endtask

	// Decide whether one side rests this cycle under the current pace
	function automatic bit rests(input bit sender);
		int pct;
		case (pace)
			PACE_A: begin
				pct = sender ? 37 : 63;
			end
			PACE_B: begin
				pct = sender ? 63 : 37;
			end
			default: begin
				pct = 0;
			end
		endcase
		return $urandom_range(99) < pct;
	endfunction

	// Step the marker checker by one accepted byte and record the result it gives
	task automatic advance_marker_check(input pkt_byte_t b);
		logic        is_mark;
		strip_beat_t beat;
		is_mark = 1'b0;
		if (marks_hit < MARK_COUNT && pkt_offset < MAX_PACKET_BYTES) begin
			if (pkt_offset == {1'b0, cfg_pos[marks_hit[1:0]]}) begin
				is_mark = 1'b1;
				if (b.data != cfg_markers[31 - 8 * marks_hit[1:0] -: 8]) begin
					pkt_bad = 1'b1;
				end
				marks_hit = marks_hit + 3'd1;
			end
		end
		// Saturate the offset at the packet size limit
		if (pkt_offset < MAX_PACKET_BYTES) begin
			pkt_offset = pkt_offset + 12'd1;
		end
		if (is_mark && !b.last) begin
			return;
		end
		beat.data = is_mark ? 8'h00 : b.data;
		beat.kept = !is_mark;
		beat.last = b.last;
		beat.dropped = 1'b0;
		beat.drop_total = '0;
		if (b.last) begin
			beat.dropped = pkt_bad || (marks_hit < MARK_COUNT);
			if (beat.dropped) begin
				drops = drops + 1;
			end
			beat.drop_total = drops;
			pkt_offset = '0;
			pkt_bad = 1'b0;
			marks_hit = '0;
		end
		expected_beats.push_back(beat);
	endtask

	// Sample both channels at the rising edge
	always @(posedge clk) begin : watch
		strip_beat_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (expected_beats.size() == 0) begin
					note_error($sformatf("unexpected result byte=%h kept=%b last=%b drop=%b total=%0d",
						out_byte, out_valid, out_last, verdict, drop_total));
				end else begin
					want = expected_beats.pop_front();
					if (out_byte !== want.data || out_valid !== want.kept ||
							out_last !== want.last || verdict !== want.dropped ||
							drop_total !== want.drop_total) begin
						note_error($sformatf(
							"expected byte=%h kept=%b last=%b drop=%b total=%0d, got byte=%h kept=%b last=%b drop=%b total=%0d",
							want.data, want.kept, want.last, want.dropped, want.drop_total,
							out_byte, out_valid, out_last, verdict, drop_total));
					end
				end
			end
			if (in_valid && !in_stall) begin
				advance_marker_check('{in_byte, in_last});
			end
		end
		in_took <= arst_n && in_valid && !in_stall;
	end

	// Drive the byte channel and the result stall at the falling edge
	always @(negedge clk) begin : drive
		pkt_byte_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			res_stall <= 1'b0;
		end else begin
			// Hold a pending transaction until it is taken
			if (!in_valid || in_took) begin
				if (byte_backlog.size() != 0 && !rests(1'b1)) begin
					nxt = byte_backlog.pop_front();
					in_byte <= nxt.data;
					in_last <= nxt.last;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			res_stall <= rests(1'b0);
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		// Mirror the write; indexes past the list are ignored
		case (idx)
			REG_MARKERS: cfg_markers = val;
			REG_POS_0: cfg_pos[0] = val[POS_W-1:0];
			REG_POS_1: cfg_pos[1] = val[POS_W-1:0];
			REG_POS_2: cfg_pos[2] = val[POS_W-1:0];
			REG_POS_3: cfg_pos[3] = val[POS_W-1:0];
			default: ;
		endcase
	endtask

	// Write all four offsets, with junk above the offset bits
	task automatic set_offsets(input int p0, input int p1, input int p2, input int p3);
		reg_write(REG_POS_0, {21'($urandom()), POS_W'(p0)});
		reg_write(REG_POS_1, {21'($urandom()), POS_W'(p1)});
		reg_write(REG_POS_2, {21'($urandom()), POS_W'(p2)});
		reg_write(REG_POS_3, {21'($urandom()), POS_W'(p3)});
	endtask

	task automatic push_byte(input logic [7:0] data, input logic last);
		byte_backlog.push_back('{data, last});
	endtask

	// Build one packet that carries the configured markers, each spoiled by chance
	task automatic queue_packet(input int len, input int spoil_pct);
		int k;
		logic [7:0] b;
		k = 0;
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom_range(255));
			if (k < MARK_COUNT && i == int'(cfg_pos[k])) begin
				if ($urandom_range(99) >= spoil_pct) begin
					b = cfg_markers[31 - 8 * k -: 8];
				end
				k++;
			end
			push_byte(b, i == len - 1);
		end
	endtask

	// Mostly well-formed packets, some cut short, some pure noise
	task automatic queue_random_packets(input int budget);
		int count;
		int span;
		int len;
		int pick;
		count = 0;
		span = int'(cfg_pos[3]) + 1;
		while (count < budget) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				len = span + $urandom_range(12);
				queue_packet(len, 8);
			end else if (pick < 85) begin
				len = $urandom_range(span, 1);
				queue_packet(len, 8);
			end else begin
				len = $urandom_range(40, 1);
				queue_packet(len, 100);
			end
			count += len;
		end
	endtask

	task automatic drain();
		while (byte_backlog.size() != 0 || in_valid || expected_beats.size() != 0) begin
			@(posedge clk);
		end
		// Let a trailing marker byte clear the pipeline
		repeat (4) @(posedge clk);
	endtask

	// Random strictly ascending offsets starting near zero
	task automatic random_ascending(input int step);
		int p0;
		int p1;
		int p2;
		p0 = $urandom_range(step - 1);
		p1 = p0 + $urandom_range(step, 1);
		p2 = p1 + $urandom_range(step, 1);
		set_offsets(p0, p1, p2, p2 + $urandom_range(step, 1));
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset layout, packets reaching the default offsets
		pace = PACE_A;
		queue_random_packets(200);
		drain();

		// Lowest offsets, extreme marker values
		reg_write(REG_MARKERS, 32'hFF00_A55A);
		reg_write(REG_UNUSED, $urandom());
		set_offsets(0, 1, 2, 3);
		// One-byte packet that is a matching marker: too short
		push_byte(8'hFF, 1'b1);
		// Exact markers, packet ends on the last marker
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hA5, 1'b0);
		push_byte(8'h5A, 1'b1);
		// Exact markers followed by extreme data bytes
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hA5, 1'b0);
		push_byte(8'h5A, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b1);
		// Third marker wrong: dropped, marker still stripped
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h5A, 1'b0);
		push_byte(8'h77, 1'b1);
		queue_random_packets(220);
		drain();

		pace = PACE_B;
		reg_write(REG_MARKERS, $urandom());
		random_ascending(8);
		queue_random_packets(260);
		drain();

		// Highest offset: short packets never reach it and are dropped
		reg_write(REG_MARKERS, 32'h0000_0000);
		set_offsets(0, 2047, 0, 2047);
		queue_packet(40, 0);
		queue_packet(3, 0);
		drain();

		pace = PACE_FULL;
		reg_write(REG_MARKERS, 32'hFFFF_FFFF);
		random_ascending(10);
		queue_random_packets(170);
		drain();
		reg_write(REG_MARKERS, $urandom());
		random_ascending(10);
		queue_random_packets(170);
		drain();

		// Offsets in any order, equal ones included
		reg_write(REG_MARKERS, $urandom());
		set_offsets($urandom_range(20), $urandom_range(20), $urandom_range(20),
			$urandom_range(20));
		queue_random_packets(250);
		drain();

		errors += expected_beats.size();
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
